// ===== hdl/morse_code_translator_unit_defines.svh =====
// assertion macros used by the translator back end
`ifndef MORSE_CODE_TRANSLATOR_UNIT_DEFINES_SVH
`define MORSE_CODE_TRANSLATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define MCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define MCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mcode_pkg.sv =====
// types, constants and code tables of the morse code translator
package mcode_pkg;

   localparam int MAX_SYMBOLS = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int NUM_LETTERS = 26;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_MASK    = 8'hDF;
   localparam logic [7:0] CHAR_BAD     = 8'h00;

   // length in bits 6..4, pattern in bits 3..0, first symbol highest, dash = 1
   localparam logic [6:0] LETTER_CODE [NUM_LETTERS] = '{
      7'h21, 7'h48, 7'h4A, 7'h34, 7'h10, 7'h42, 7'h36, 7'h40, 7'h20, 7'h47,
      7'h35, 7'h44, 7'h23, 7'h22, 7'h37, 7'h46, 7'h4D, 7'h32, 7'h30, 7'h11,
      7'h31, 7'h41, 7'h33, 7'h49, 7'h4B, 7'h4C
   };

   typedef struct packed {
      logic [7:0] char_in;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       bad_code;
      logic       last;
   } rsp_type;

   // one unit of work for the back end
   typedef struct packed {
      logic       encode;   // 1: emit symbols then space, 0: emit one decoded result
      logic [2:0] len;
      logic [3:0] pat;
      logic [7:0] dec_char;
      logic       bad;
   } job_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
             ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
   endfunction

   function automatic logic [6:0] encode_letter(input logic [7:0] c);
      logic [7:0] idx;
      idx = (c & CASE_MASK) - CHAR_UPPER_A;
      if (idx > 8'(NUM_LETTERS - 1)) begin
         idx = 8'd0;
      end
      return LETTER_CODE[idx[4:0]];
   endfunction

   // returns {bad, char}
   function automatic logic [8:0] decode_run(input logic [2:0] cnt, input logic [3:0] bits);
      logic       found;
      logic [7:0] ch;
      found = 1'b0;
      ch    = CHAR_BAD;
      if ((cnt >= 3'd1) && (cnt <= 3'(MAX_SYMBOLS))) begin
         for (int i = 0; i < NUM_LETTERS; i++) begin
            if (!found && (LETTER_CODE[i][6:4] == cnt) && (LETTER_CODE[i][3:0] == bits)) begin
               found = 1'b1;
               ch    = CHAR_UPPER_A + 8'(i);
            end
         end
      end
      return {!found, ch};
   endfunction

endpackage

// ===== hdl/mcode_front.sv =====
// front end: line mode tracking, run collection and job classification
module mcode_front
   import mcode_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    job_push,
   output job_type job
);

   logic       line_mode_ff, line_mode_in;
   logic       at_start_ff, at_start_in;
   logic [3:0] bits_ff, bits_in;
   logic [2:0] count_ff, count_in;

   logic       mode_eff;
   logic [3:0] bits_eff, bits_new;
   logic [2:0] count_eff, count_new;
   logic       is_sym;
   logic [6:0] code;
   logic [8:0] dec;
   logic       close;

   always_comb begin
      mode_eff  = at_start_ff ? is_letter(req.char_in) : line_mode_ff;
      bits_eff  = at_start_ff ? 4'd0 : bits_ff;
      count_eff = at_start_ff ? 3'd0 : count_ff;
      is_sym    = (req.char_in == CHAR_DOT) || (req.char_in == CHAR_DASH);

      if (count_eff < 3'(MAX_SYMBOLS)) begin
         bits_new  = {bits_eff[2:0], req.char_in == CHAR_DASH};
         count_new = count_eff + 3'd1;
      end else begin
         bits_new  = bits_eff;
         count_new = 3'(MAX_SYMBOLS + 1);
      end

      code = encode_letter(req.char_in);
      dec  = is_sym ? decode_run(count_new, bits_new) : decode_run(count_eff, bits_eff);

      close = 1'b0;
      job   = '0;
      job_push    = 1'b0;
      line_mode_in = mode_eff;
      bits_in      = bits_eff;
      count_in     = count_eff;

      if (mode_eff) begin
         if (is_letter(req.char_in)) begin
            job_push   = accept;
            job.encode = 1'b1;
            job.len    = code[6:4];
            job.pat    = code[3:0];
         end
      end else begin
         if (is_sym) begin
            bits_in  = bits_new;
            count_in = count_new;
            close    = req.line_end;
         end else begin
            close = (count_eff != 3'd0);
         end
         if (close) begin
            job_push     = accept;
            job.dec_char = dec[7:0];
            job.bad      = dec[8];
            bits_in      = 4'd0;
            count_in     = 3'd0;
         end
      end

      at_start_in = req.line_end;
      if (req.line_end) begin
         bits_in  = 4'd0;
         count_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_mode_ff <= 1'b0;
         at_start_ff  <= 1'b1;
         bits_ff      <= 4'd0;
         count_ff     <= 3'd0;
      end else if (accept) begin
         line_mode_ff <= line_mode_in;
         at_start_ff  <= at_start_in;
         bits_ff      <= bits_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ===== hdl/mcode_queue.sv =====
// short job queue between front and back end
module mcode_queue
   import mcode_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/mcode_back.sv =====
// back end: steps through a job, one result per transfer
`include "morse_code_translator_unit_defines.svh"
module mcode_back
   import mcode_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  job_type q_head,
   input  logic    q_empty,
   output logic    q_pop,
   output rsp_type rsp,
   output logic    rsp_empty,
   input  logic    rsp_pop
);

   logic       valid_ff, valid_in;
   job_type    job_ff;
   logic [2:0] step_ff, step_in;
   logic [2:0] shift;
   logic       is_last;
   logic       taken;

   always_comb begin
      shift   = job_ff.len - 3'd1 - step_ff;
      is_last = !job_ff.encode || (step_ff == job_ff.len);
      if (job_ff.encode) begin
         if (is_last) begin
            rsp.char_out = CHAR_SPACE;
         end else begin
            rsp.char_out = job_ff.pat[shift[1:0]] ? CHAR_DASH : CHAR_DOT;
         end
         rsp.bad_code = 1'b0;
      end else begin
         rsp.char_out = job_ff.dec_char;
         rsp.bad_code = job_ff.bad;
      end
      rsp.last = is_last;
   end

   assign rsp_empty = !valid_ff;
   assign taken     = valid_ff && rsp_pop;
   assign q_pop     = (!valid_ff || (taken && is_last)) && !q_empty;

   always_comb begin
      valid_in = valid_ff;
      step_in  = step_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         step_in  = 3'd0;
      end else if (taken && is_last) begin
         valid_in = 1'b0;
      end else if (taken) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   `MCT_ASSERT_NOW(a_step_in_range, clock, reset, valid_ff && job_ff.encode, step_ff <= job_ff.len, "step past end of encode job")
   `MCT_ASSERT_NOW(a_decode_single, clock, reset, valid_ff && !job_ff.encode, step_ff == 3'd0, "decode job stepped")
   `MCT_ASSERT_NEXT(a_load_starts, clock, reset, q_pop, valid_ff && (step_ff == 3'd0), "loaded job not at first step")

endmodule

// ===== hdl/morse_code_translator_unit.sv =====
// top level of the morse code translator
// the first result passes the job queue and then the back-end register
// throughput: one character per cycle in while the job queue has room; results
//    leave one per cycle while popped, an encoded letter takes 2 to 5 result transfers
// a full job queue stalls the input until the back end takes a job from it
// reset: synchronous active high; clears line state, queue and pending results
module morse_code_translator_unit
   import mcode_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   // front to queue
   logic    accept;
   logic    job_push;
   job_type job;

   // queue to back
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   job_type q_head;

   // a character transfers whenever the queue has room, even if it makes no job
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // line mode, run collection, letter lookup
   mcode_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .job_push (job_push),
      .job      (job)
   );

   // decouples classification from result stepping
   mcode_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // one result per transfer; for a letter, symbols first then the closing space
   mcode_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp       (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule
